// File: rtl/core/fmtc_pkg.sv
// fan mode and temperature curve: shared types, constants and register indexes
// no dependencies; used by every module of the core

package fmtc_pkg;

	localparam int TEMP_W = 12;
	localparam int PCT_W  = 7;
	localparam int MODE_W = 2;
	localparam int IDX_W  = 4;
	localparam int NUM_BP = 4;

	// run mode codes
	localparam logic [MODE_W-1:0] MODE_OFF    = 2'd0;
	localparam logic [MODE_W-1:0] MODE_MANUAL = 2'd1;
	localparam logic [MODE_W-1:0] MODE_AUTO   = 2'd2;

	// register indexes: breakpoint temperatures first, then breakpoint percents
	localparam logic [IDX_W-1:0] REG_FIRST_TEMP = 4'd0;
	localparam logic [IDX_W-1:0] REG_FIRST_PCT  = 4'd4;
	localparam logic [IDX_W-1:0] REG_COUNT      = 4'd8;

	localparam logic [PCT_W-1:0] PCT_MAX      = 7'd100;
	localparam logic [PCT_W-1:0] DEADBAND     = 7'd3;
	localparam logic [PCT_W-1:0] BOOT_PERCENT = 7'd0;

	localparam logic [NUM_BP-1:0][TEMP_W-1:0] BP_TEMP_RST =
		{12'd330, 12'd300, 12'd270, 12'd240};
	localparam logic [NUM_BP-1:0][PCT_W-1:0] BP_PCT_RST =
		{7'd100, 7'd70, 7'd40, 7'd20};

	typedef struct packed {
		logic [NUM_BP-1:0][TEMP_W-1:0] bp_temp;
		logic [NUM_BP-1:0][PCT_W-1:0]  bp_pct;
	} cfg_t;

endpackage

// File: rtl/core/fmtc_cfg.sv
// configuration registers: four breakpoint temperatures and four breakpoint percents
// depends on fmtc_pkg

module fmtc_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [fmtc_pkg::IDX_W-1:0]       cfg_index,
	input  logic [fmtc_pkg::TEMP_W-1:0]      cfg_data,
	output fmtc_pkg::cfg_t                   cfg
);

	fmtc_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bp_temp <= fmtc_pkg::BP_TEMP_RST;
			cfg_q.bp_pct  <= fmtc_pkg::BP_PCT_RST;
		end else if (cfg_we) begin
			if (cfg_index < fmtc_pkg::REG_FIRST_PCT) begin
				cfg_q.bp_temp[cfg_index[1:0]] <= cfg_data;
			end else if (cfg_index < fmtc_pkg::REG_COUNT) begin
				cfg_q.bp_pct[cfg_index[1:0]] <= cfg_data[fmtc_pkg::PCT_W-1:0];
			end
		end
	end

	assign cfg = cfg_q;

endmodule

// File: rtl/core/fmtc_curve.sv
// piecewise-linear curve evaluation with one shared multiplier and a serial
// restoring divider under a small sequencer; depends on fmtc_pkg

module fmtc_curve (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [fmtc_pkg::TEMP_W-1:0]       temp,
	input  fmtc_pkg::cfg_t                    cfg,
	output logic                              done,
	output logic [fmtc_pkg::PCT_W-1:0]        pct
);

	localparam int SPAN_W = fmtc_pkg::TEMP_W;        // span, dt: 1..4095; rest: 0..4094
	localparam int PROD_W = fmtc_pkg::PCT_W + SPAN_W;
	localparam int REM_W  = PROD_W + 2;

	typedef enum logic [5:0] {
		C_IDLE  = 6'b000001,
		C_SETUP = 6'b000010,
		C_MUL_A = 6'b000100,
		C_MUL_B = 6'b001000,
		C_DIV   = 6'b010000,
		C_DONE  = 6'b100000
	} crv_state_t;

	crv_state_t                        state_q;
	logic [fmtc_pkg::TEMP_W-1:0]       t_q;
	logic [1:0]                        seg_q;
	logic [SPAN_W-1:0]                 span_q;
	logic [SPAN_W-1:0]                 dt_q;
	logic [SPAN_W-1:0]                 rest_q;
	logic [fmtc_pkg::PCT_W-1:0]        pl_q;
	logic [fmtc_pkg::PCT_W-1:0]        ph_q;
	logic [PROD_W-1:0]                 acc_q;
	logic [REM_W-1:0]                  rem_q;
	logic [2:0]                        k_q;
	logic [fmtc_pkg::PCT_W-2:0]        quo_q;
	logic [fmtc_pkg::PCT_W-1:0]        res_q;

	logic signed [fmtc_pkg::TEMP_W-1:0] t_s;
	logic                               le0, le1, le2, le3;
	logic                               above;
	logic signed [SPAN_W:0]             tl_s, th_s, tq_s;
	logic signed [SPAN_W:0]             span_s, dt_s, rest_s;
	logic [fmtc_pkg::PCT_W-1:0]         mul_a;
	logic [SPAN_W-1:0]                  mul_b;
	logic [PROD_W-1:0]                  prod;
	logic [REM_W-1:0]                   num_sum;
	logic [REM_W-1:0]                   divisor;
	logic [REM_W:0]                     trial;
	logic                               qbit;
	logic [fmtc_pkg::PCT_W-1:0]         quo_nx;

	function automatic logic [fmtc_pkg::PCT_W-1:0] sat_pct(
		input logic [fmtc_pkg::PCT_W-1:0] p);
		sat_pct = (p > fmtc_pkg::PCT_MAX) ? fmtc_pkg::PCT_MAX : p;
	endfunction

	// breakpoint compares against the incoming sample
	assign t_s = $signed(temp);
	assign le0 = t_s <= $signed(cfg.bp_temp[0]);
	assign le1 = t_s <= $signed(cfg.bp_temp[1]);
	assign le2 = t_s <= $signed(cfg.bp_temp[2]);
	assign le3 = t_s <= $signed(cfg.bp_temp[3]);
	// above every upper breakpoint, also when they are unordered
	assign above = !(le1 || le2 || le3);

	// segment end points, widened by one bit for the differences
	assign tl_s   = {cfg.bp_temp[seg_q][fmtc_pkg::TEMP_W-1], cfg.bp_temp[seg_q]};
	assign th_s   = {cfg.bp_temp[seg_q + 2'd1][fmtc_pkg::TEMP_W-1],
		cfg.bp_temp[seg_q + 2'd1]};
	assign tq_s   = {t_q[fmtc_pkg::TEMP_W-1], t_q};
	assign span_s = th_s - tl_s;
	assign dt_s   = tq_s - tl_s;
	assign rest_s = th_s - tq_s;

	// shared multiplier: pl * (th - t), then ph * (t - tl)
	assign mul_a   = (state_q == C_MUL_A) ? pl_q : ph_q;
	assign mul_b   = (state_q == C_MUL_A) ? rest_q : dt_q;
	assign prod    = PROD_W'(mul_a) * PROD_W'(mul_b);
	assign num_sum = ((REM_W'(acc_q) + REM_W'(prod)) << 1) + REM_W'(span_q);

	// restoring divide by 2*span, one quotient bit per cycle
	assign divisor = REM_W'({span_q, 1'b0}) << k_q;
	assign trial   = {1'b0, rem_q} - {1'b0, divisor};
	assign qbit    = !trial[REM_W];
	assign quo_nx  = {quo_q, qbit};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
		end else begin
			unique case (state_q)
				C_IDLE: begin
					if (start) begin
						if (le0 || above) begin
							state_q <= C_DONE;
						end else begin
							state_q <= C_SETUP;
						end
					end
				end
				C_SETUP: begin
					if (span_s <= 0) begin
						state_q <= C_DONE;
					end else begin
						state_q <= C_MUL_A;
					end
				end
				C_MUL_A: state_q <= C_MUL_B;
				C_MUL_B: state_q <= C_DIV;
				C_DIV: begin
					if (k_q == 3'd0) begin
						state_q <= C_DONE;
					end
				end
				C_DONE:  state_q <= C_IDLE;
				default: state_q <= C_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			C_IDLE: begin
				t_q <= temp;
				if (le0) begin
					res_q <= sat_pct(cfg.bp_pct[0]);
				end else if (above) begin
					res_q <= sat_pct(cfg.bp_pct[3]);
				end
				priority if (le1) seg_q <= 2'd0;
				else if (le2)     seg_q <= 2'd1;
				else              seg_q <= 2'd2;
			end
			C_SETUP: begin
				span_q <= span_s[SPAN_W-1:0];
				dt_q   <= dt_s[SPAN_W-1:0];
				rest_q <= rest_s[SPAN_W-1:0];
				pl_q   <= cfg.bp_pct[seg_q];
				ph_q   <= cfg.bp_pct[seg_q + 2'd1];
				// degenerate segment takes the upper percent
				res_q  <= sat_pct(cfg.bp_pct[seg_q + 2'd1]);
			end
			C_MUL_A: begin
				acc_q <= prod;
			end
			C_MUL_B: begin
				// 2*num + span, so the quotient comes out rounded half up
				rem_q <= num_sum;
				k_q   <= 3'd6;
				quo_q <= '0;
			end
			C_DIV: begin
				if (qbit) begin
					rem_q <= trial[REM_W-1:0];
				end
				quo_q <= quo_nx[fmtc_pkg::PCT_W-2:0];
				k_q   <= k_q - 3'd1;
				if (k_q == 3'd0) begin
					res_q <= sat_pct(quo_nx);
				end
			end
			C_DONE: begin
			end
			default: begin
			end
		endcase
	end

	assign done = (state_q == C_DONE);
	assign pct  = res_q;

endmodule

// File: rtl/core/fan_mode_and_temperature_curve_core.sv
// fan mode and temperature curve core: top level with handshakes, mode state and result register
// depends on fmtc_pkg, fmtc_cfg and fmtc_curve

// One transaction carries button presses and an optional temperature sample and
// yields one result transaction. A transaction whose valid sample falls inside a
// curve segment runs through the curve unit (breakpoint select, two passes of a
// shared 7x12 multiplier, a seven-step serial divider) before its result is
// registered. A valid sample at or below the idle breakpoint or above the upper
// breakpoints skips the segment arithmetic, and a transaction without a valid
// sample bypasses the curve unit. A result that is not taken holds the next
// result back. The block computes one transaction at a time: in_ready is high
// only while no transaction is being computed or waiting for the output register,
// and a result waits in the output register until taken while the next
// transaction may already be accepted. Configuration writes take effect at the
// next clock edge and should happen only while the block is idle.

module fan_mode_and_temperature_curve_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [fmtc_pkg::IDX_W-1:0]        cfg_index,
	input  logic [fmtc_pkg::TEMP_W-1:0]       cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              press_mode,
	input  logic                              press_up,
	input  logic                              press_down,
	input  logic                              sample_present,
	input  logic                              sample_valid,
	input  logic signed [fmtc_pkg::TEMP_W-1:0] temperature,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [fmtc_pkg::PCT_W-1:0]        fan_percent,
	output logic [fmtc_pkg::MODE_W-1:0]       run_mode,
	output logic [fmtc_pkg::PCT_W-1:0]        manual_level,
	output logic [fmtc_pkg::PCT_W-1:0]        auto_level
);

	typedef enum logic [2:0] {
		T_IDLE = 3'b001,
		T_CALC = 3'b010,
		T_OUT  = 3'b100
	} top_state_t;

	top_state_t                     state_q;
	logic [fmtc_pkg::MODE_W-1:0]    mode_q;
	logic [fmtc_pkg::PCT_W-1:0]     manual_q;
	logic [fmtc_pkg::PCT_W-1:0]     auto_q;
	logic                           out_valid_q;
	logic [fmtc_pkg::PCT_W-1:0]     fan_q;
	logic [fmtc_pkg::MODE_W-1:0]    run_mode_q;
	logic [fmtc_pkg::PCT_W-1:0]     manual_out_q;
	logic [fmtc_pkg::PCT_W-1:0]     auto_out_q;

	fmtc_pkg::cfg_t                 cfg;
	logic                           accept;
	logic                           crv_start;
	logic                           crv_done;
	logic [fmtc_pkg::PCT_W-1:0]     crv_pct;
	logic [fmtc_pkg::MODE_W-1:0]    mode_cyc;
	logic [fmtc_pkg::MODE_W-1:0]    mode_nx;
	logic [fmtc_pkg::PCT_W-1:0]     man_up;
	logic [fmtc_pkg::PCT_W-1:0]     man_nx;
	logic                           out_load;
	logic [fmtc_pkg::PCT_W-1:0]     fan_nx;
	logic [fmtc_pkg::PCT_W:0]       crv_db;
	logic [fmtc_pkg::PCT_W:0]       auto_db;
	logic                           db_pass;

	fmtc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	fmtc_curve u_curve (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (crv_start),
		.temp   (temperature),
		.cfg    (cfg),
		.done   (crv_done),
		.pct    (crv_pct)
	);

	assign in_ready  = (state_q == T_IDLE);
	assign accept    = in_valid && in_ready;
	assign crv_start = accept && sample_present && sample_valid;

	// mode press cycles off, manual, auto; up or down then forces manual
	always_comb begin
		mode_cyc = mode_q;
		if (press_mode) begin
			priority if (mode_q == fmtc_pkg::MODE_OFF) mode_cyc = fmtc_pkg::MODE_MANUAL;
			else if (mode_q == fmtc_pkg::MODE_MANUAL)  mode_cyc = fmtc_pkg::MODE_AUTO;
			else                                       mode_cyc = fmtc_pkg::MODE_OFF;
		end
		mode_nx = (press_up || press_down) ? fmtc_pkg::MODE_MANUAL : mode_cyc;
	end

	always_comb begin
		man_up = manual_q;
		if (press_up && manual_q < fmtc_pkg::PCT_MAX) begin
			man_up = manual_q + 7'd1;
		end
		man_nx = man_up;
		if (press_down && man_up != '0) begin
			man_nx = man_up - 7'd1;
		end
	end

	// deadband: take the new value only when it moved by at least DEADBAND
	assign crv_db  = {1'b0, crv_pct} + {1'b0, fmtc_pkg::DEADBAND};
	assign auto_db = {1'b0, auto_q} + {1'b0, fmtc_pkg::DEADBAND};
	assign db_pass = ({1'b0, auto_q} >= crv_db) || ({1'b0, crv_pct} >= auto_db);

	always_comb begin
		unique case (mode_q)
			fmtc_pkg::MODE_MANUAL: fan_nx = manual_q;
			fmtc_pkg::MODE_AUTO:   fan_nx = auto_q;
			default:               fan_nx = '0;
		endcase
	end

	assign out_load = (state_q == T_OUT) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= T_IDLE;
			mode_q      <= fmtc_pkg::MODE_OFF;
			manual_q    <= fmtc_pkg::BOOT_PERCENT;
			auto_q      <= fmtc_pkg::BOOT_PERCENT;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				T_IDLE: begin
					if (accept) begin
						mode_q   <= mode_nx;
						manual_q <= man_nx;
						if (sample_present && !sample_valid) begin
							auto_q <= '0;
						end
						state_q <= crv_start ? T_CALC : T_OUT;
					end
				end
				T_CALC: begin
					if (crv_done) begin
						if (db_pass) begin
							auto_q <= crv_pct;
						end
						state_q <= T_OUT;
					end
				end
				T_OUT: begin
					if (out_load) begin
						state_q <= T_IDLE;
					end
				end
				default: state_q <= T_IDLE;
			endcase

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result register, loaded when the previous transaction has left
	always_ff @(posedge clk) begin
		if (out_load) begin
			fan_q        <= fan_nx;
			run_mode_q   <= mode_q;
			manual_out_q <= manual_q;
			auto_out_q   <= auto_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign fan_percent  = fan_q;
	assign run_mode     = run_mode_q;
	assign manual_level = manual_out_q;
	assign auto_level   = auto_out_q;

endmodule

// File: tb/sv/testbench.sv
// testbench for fan_mode_and_temperature_curve_core: directed table, then random transactions
// checked against a local model of mode, manual step and curve logic; depends on fmtc_pkg

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic                               press_mode;
		logic                               press_up;
		logic                               press_down;
		logic                               sample_present;
		logic                               sample_valid;
		logic signed [fmtc_pkg::TEMP_W-1:0] temperature;
	} press_sample_t;

	typedef struct packed {
		logic [fmtc_pkg::PCT_W-1:0]  fan_percent;
		logic [fmtc_pkg::MODE_W-1:0] run_mode;
		logic [fmtc_pkg::PCT_W-1:0]  manual_level;
		logic [fmtc_pkg::PCT_W-1:0]  auto_level;
	} fan_status_t;

	typedef struct {
		press_sample_t stim;
		bit            pinned;
		fan_status_t   want;
	} dir_row_t;

	logic                               clk = 1'b0;
	logic                               arst_n = 1'b0;
	logic                               cfg_we = 1'b0;
	logic [fmtc_pkg::IDX_W-1:0]         cfg_index = '0;
	logic [fmtc_pkg::TEMP_W-1:0]        cfg_data = '0;
	logic                               in_valid = 1'b0;
	logic                               in_ready;
	logic                               press_mode = 1'b0;
	logic                               press_up = 1'b0;
	logic                               press_down = 1'b0;
	logic                               sample_present = 1'b0;
	logic                               sample_valid = 1'b0;
	logic signed [fmtc_pkg::TEMP_W-1:0] temperature = '0;
	logic                               out_valid;
	logic                               out_ready = 1'b0;
	logic [fmtc_pkg::PCT_W-1:0]         fan_percent;
	logic [fmtc_pkg::MODE_W-1:0]        run_mode;
	logic [fmtc_pkg::PCT_W-1:0]         manual_level;
	logic [fmtc_pkg::PCT_W-1:0]         auto_level;

	fan_mode_and_temperature_curve_core uut (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// local copy of the curve settings and controller state
	int                          bp_temp_cfg [fmtc_pkg::NUM_BP];
	logic [fmtc_pkg::PCT_W-1:0]  bp_pct_cfg [fmtc_pkg::NUM_BP];
	logic [fmtc_pkg::MODE_W-1:0] ctl_mode;
	logic [fmtc_pkg::PCT_W-1:0]  ctl_manual;
	logic [fmtc_pkg::PCT_W-1:0]  ctl_auto;

	fan_status_t   pending_status[$];
	press_sample_t drive_txn;
	bit            drive_pinned;
	fan_status_t   drive_want;
	bit            no_idle = 1'b0;
	int            error_count = 0;
	int            txn_count = 0;
	int            result_count = 0;
	int            write_count = 0;

	function automatic logic [fmtc_pkg::PCT_W-1:0] clamp_pct(input longint v);
		if (v < 0)
			return '0;
		if (v > 100)
			return fmtc_pkg::PCT_MAX;
		return v[fmtc_pkg::PCT_W-1:0];
	endfunction

	function automatic logic [fmtc_pkg::PCT_W-1:0] segment_pct(input longint t,
		input longint tl, input longint pl, input longint th, input longint ph);
		longint dt, span, num;
		if (th <= tl)
			return clamp_pct(ph);
		dt = t - tl;
		span = th - tl;
		num = pl * span + (ph - pl) * dt;
		if (num < 0)
			return '0;
		// exact quotient rounded half up
		return clamp_pct((2 * num + span) / (2 * span));
	endfunction

	function automatic logic [fmtc_pkg::PCT_W-1:0] curve_percent(input int t);
		if (t <= bp_temp_cfg[0])
			return clamp_pct(bp_pct_cfg[0]);
		if (t <= bp_temp_cfg[1])
			return segment_pct(t, bp_temp_cfg[0], bp_pct_cfg[0], bp_temp_cfg[1], bp_pct_cfg[1]);
		if (t <= bp_temp_cfg[2])
			return segment_pct(t, bp_temp_cfg[1], bp_pct_cfg[1], bp_temp_cfg[2], bp_pct_cfg[2]);
		if (t <= bp_temp_cfg[3])
			return segment_pct(t, bp_temp_cfg[2], bp_pct_cfg[2], bp_temp_cfg[3], bp_pct_cfg[3]);
		return clamp_pct(bp_pct_cfg[3]);
	endfunction

	function automatic fan_status_t advance_controller(input press_sample_t x);
		logic [fmtc_pkg::PCT_W-1:0] target;
		int                         diff;
		fan_status_t                r;
		if (x.press_mode) begin
			case (ctl_mode)
				fmtc_pkg::MODE_OFF:    ctl_mode = fmtc_pkg::MODE_MANUAL;
				fmtc_pkg::MODE_MANUAL: ctl_mode = fmtc_pkg::MODE_AUTO;
				default:               ctl_mode = fmtc_pkg::MODE_OFF;
			endcase
		end
		if (x.press_up) begin
			ctl_mode = fmtc_pkg::MODE_MANUAL;
			ctl_manual = clamp_pct(longint'(ctl_manual) + 1);
		end
		if (x.press_down) begin
			ctl_mode = fmtc_pkg::MODE_MANUAL;
			ctl_manual = clamp_pct(longint'(ctl_manual) - 1);
		end
		if (x.sample_present) begin
			if (x.sample_valid) begin
				target = curve_percent(int'(x.temperature));
				diff = int'(target) - int'(ctl_auto);
				if (diff < 0)
					diff = -diff;
				if (diff >= int'(fmtc_pkg::DEADBAND))
					ctl_auto = target;
			end else begin
				ctl_auto = '0;
			end
		end
		if (ctl_mode == fmtc_pkg::MODE_MANUAL)
			r.fan_percent = ctl_manual;
		else if (ctl_mode == fmtc_pkg::MODE_AUTO)
			r.fan_percent = ctl_auto;
		else
			r.fan_percent = '0;
		r.run_mode = ctl_mode;
		r.manual_level = ctl_manual;
		r.auto_level = ctl_auto;
		return r;
	endfunction

	function automatic int draw_gap();
		return no_idle ? 0 : int'($urandom_range(0, 8));
	endfunction

	// predict on input acceptance, compare on result acceptance
	always @(posedge clk) begin
		fan_status_t predicted;
		fan_status_t want;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				predicted = advance_controller(drive_txn);
				pending_status.push_back(drive_pinned ? drive_want : predicted);
				txn_count++;
			end
			if (out_valid && out_ready) begin
				if (pending_status.size() == 0) begin
					$error("result transaction with nothing pending");
					error_count++;
				end else begin
					want = pending_status.pop_front();
					result_count++;
					if (fan_percent !== want.fan_percent) begin
						$error("fan_percent: expected %0d, got %0d", want.fan_percent, fan_percent);
						error_count++;
					end
					if (run_mode !== want.run_mode) begin
						$error("run_mode: expected %0d, got %0d", want.run_mode, run_mode);
						error_count++;
					end
					if (manual_level !== want.manual_level) begin
						$error("manual_level: expected %0d, got %0d", want.manual_level,
							manual_level);
						error_count++;
					end
					if (auto_level !== want.auto_level) begin
						$error("auto_level: expected %0d, got %0d", want.auto_level, auto_level);
						error_count++;
					end
				end
			end
		end
	end

	// result side: random stall before each result transaction
	initial begin
		int stall;
		@(negedge clk);
		forever begin
			stall = draw_gap();
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			@(negedge clk);
		end
	end

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send_txn(input press_sample_t x, input bit pinned, input fan_status_t want);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		drive_txn = x;
		drive_pinned = pinned;
		drive_want = want;
		in_valid <= 1'b1;
		press_mode <= x.press_mode;
		press_up <= x.press_up;
		press_down <= x.press_down;
		sample_present <= x.sample_present;
		sample_valid <= x.sample_valid;
		temperature <= x.temperature;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	// leaves cfg_we high so back-to-back writes need no toggle
	task automatic write_reg(input logic [fmtc_pkg::IDX_W-1:0] idx,
		input logic [fmtc_pkg::TEMP_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		if (idx < fmtc_pkg::REG_FIRST_PCT)
			bp_temp_cfg[idx] = int'($signed(data));
		else if (idx < fmtc_pkg::REG_COUNT)
			bp_pct_cfg[idx - fmtc_pkg::REG_FIRST_PCT] = data[fmtc_pkg::PCT_W-1:0];
		write_count++;
		@(negedge clk);
	endtask

	task automatic load_curve(input int kind);
		int tq[$];
		int base;
		for (int i = 0; i < fmtc_pkg::NUM_BP; i++) begin
			case (kind)
				0: tq.push_back(int'($signed(fmtc_pkg::BP_TEMP_RST[i])));
				1: tq.push_back(i < 2 ? -2048 : 2047);
				2: tq.push_back(int'($urandom_range(0, 1650)) - 400);
				3: tq.push_back(int'($urandom_range(0, 4095)) - 2048);
				4: tq.push_back(0);
				default: tq.push_back(int'($urandom_range(1, 3)));
			endcase
		end
		base = int'($urandom_range(0, 1650)) - 400;
		if (kind == 2)
			tq.sort();
		if (kind == 4)
			foreach (tq[i]) tq[i] = base;
		// narrow spans so that half-way values come up often
		if (kind == 5) begin
			tq[0] = base - 12;
			for (int i = 1; i < fmtc_pkg::NUM_BP; i++)
				tq[i] = tq[i - 1] + tq[i];
		end
		for (int i = 0; i < fmtc_pkg::NUM_BP; i++)
			write_reg(fmtc_pkg::REG_FIRST_TEMP + fmtc_pkg::IDX_W'(i),
				fmtc_pkg::TEMP_W'(tq[i]));
		for (int i = 0; i < fmtc_pkg::NUM_BP; i++) begin
			case (kind)
				0: write_reg(fmtc_pkg::REG_FIRST_PCT + fmtc_pkg::IDX_W'(i),
					fmtc_pkg::TEMP_W'(fmtc_pkg::BP_PCT_RST[i]));
				1: write_reg(fmtc_pkg::REG_FIRST_PCT + fmtc_pkg::IDX_W'(i),
					(i % 2) ? fmtc_pkg::TEMP_W'(127) : '0);
				3: write_reg(fmtc_pkg::REG_FIRST_PCT + fmtc_pkg::IDX_W'(i),
					fmtc_pkg::TEMP_W'($urandom_range(0, 4095)));
				4: write_reg(fmtc_pkg::REG_FIRST_PCT + fmtc_pkg::IDX_W'(i),
					fmtc_pkg::TEMP_W'($urandom_range(0, 127)));
				default: write_reg(fmtc_pkg::REG_FIRST_PCT + fmtc_pkg::IDX_W'(i),
					fmtc_pkg::TEMP_W'($urandom_range(0, 100)));
			endcase
		end
		// out-of-range index, must be ignored
		write_reg(fmtc_pkg::REG_COUNT + fmtc_pkg::IDX_W'($urandom_range(0, 7)),
			fmtc_pkg::TEMP_W'($urandom_range(0, 4095)));
		cfg_we <= 1'b0;
	endtask

	function automatic press_sample_t random_item();
		press_sample_t x;
		int            t;
		int            pick;
		x.press_mode = ($urandom_range(0, 99) < 12);
		x.press_up = ($urandom_range(0, 99) < 10);
		x.press_down = ($urandom_range(0, 99) < 10);
		x.sample_present = ($urandom_range(0, 99) < 85);
		x.sample_valid = ($urandom_range(0, 99) < 88);
		pick = int'($urandom_range(0, 9));
		// mostly near a breakpoint, where segments and deadband matter
		if (pick < 6) begin
			t = bp_temp_cfg[$urandom_range(0, fmtc_pkg::NUM_BP - 1)]
				+ int'($urandom_range(0, 80)) - 40;
			if (t < -2048)
				t = -2048;
			if (t > 2047)
				t = 2047;
		end else if (pick < 8) begin
			t = int'($urandom_range(0, 1650)) - 400;
		end else begin
			t = int'($urandom_range(0, 4095)) - 2048;
		end
		x.temperature = t[fmtc_pkg::TEMP_W-1:0];
		return x;
	endfunction

	initial begin
		#10ms;
		$display("testbench: errors");
		$finish;
	end

	initial begin
		dir_row_t      directed_rows [20];
		press_sample_t x;
		bit            upward;
		int            run_len;

		directed_rows = '{
			'{'{0, 0, 0, 0, 0, 12'd0},   1, '{7'd0,   fmtc_pkg::MODE_OFF,    7'd0, 7'd0}},
			'{'{0, 0, 0, 1, 1, 12'h800}, 1, '{7'd0,   fmtc_pkg::MODE_OFF,    7'd0, 7'd20}},
			'{'{1, 0, 0, 0, 1, 12'h7ff}, 1, '{7'd0,   fmtc_pkg::MODE_MANUAL, 7'd0, 7'd20}},
			'{'{0, 0, 1, 0, 0, 12'd0},   1, '{7'd0,   fmtc_pkg::MODE_MANUAL, 7'd0, 7'd20}},
			'{'{0, 1, 0, 0, 0, 12'd0},   1, '{7'd1,   fmtc_pkg::MODE_MANUAL, 7'd1, 7'd20}},
			'{'{1, 0, 0, 1, 1, 12'h7ff}, 1, '{7'd100, fmtc_pkg::MODE_AUTO,   7'd1, 7'd100}},
			'{'{0, 0, 0, 1, 0, 12'd0},   1, '{7'd0,   fmtc_pkg::MODE_AUTO,   7'd1, 7'd0}},
			'{'{1, 0, 0, 0, 0, 12'd0},   1, '{7'd0,   fmtc_pkg::MODE_OFF,    7'd1, 7'd0}},
			'{'{1, 1, 1, 0, 0, 12'd0},   1, '{7'd1,   fmtc_pkg::MODE_MANUAL, 7'd1, 7'd0}},
			'{'{1, 0, 0, 1, 1, 12'd240}, 1, '{7'd20,  fmtc_pkg::MODE_AUTO,   7'd1, 7'd20}},
			'{'{0, 0, 0, 1, 1, 12'd241}, 1, '{7'd20,  fmtc_pkg::MODE_AUTO,   7'd1, 7'd20}},
			'{'{0, 0, 0, 1, 1, 12'd255}, 1, '{7'd30,  fmtc_pkg::MODE_AUTO,   7'd1, 7'd30}},
			'{'{0, 0, 0, 1, 1, 12'd285}, 1, '{7'd55,  fmtc_pkg::MODE_AUTO,   7'd1, 7'd55}},
			'{'{0, 0, 0, 1, 1, 12'd330}, 1, '{7'd100, fmtc_pkg::MODE_AUTO,   7'd1, 7'd100}},
			'{'{0, 0, 0, 1, 1, 12'd331}, 1, '{7'd100, fmtc_pkg::MODE_AUTO,   7'd1, 7'd100}},
			'{'{0, 0, 0, 1, 1, 12'd256}, 0, '0},
			'{'{0, 0, 0, 1, 1, 12'd1250}, 0, '0},
			'{'{0, 0, 0, 1, 1, 12'he70}, 0, '0},
			'{'{0, 1, 1, 1, 0, 12'hfff}, 1, '{7'd1,   fmtc_pkg::MODE_MANUAL, 7'd1, 7'd0}},
			'{'{1, 0, 0, 0, 1, 12'd0},   1, '{7'd0,   fmtc_pkg::MODE_AUTO,   7'd1, 7'd0}}
		};

		for (int i = 0; i < fmtc_pkg::NUM_BP; i++) begin
			bp_temp_cfg[i] = int'($signed(fmtc_pkg::BP_TEMP_RST[i]));
			bp_pct_cfg[i] = fmtc_pkg::BP_PCT_RST[i];
		end
		ctl_mode = fmtc_pkg::MODE_OFF;
		ctl_manual = fmtc_pkg::BOOT_PERCENT;
		ctl_auto = fmtc_pkg::BOOT_PERCENT;

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i])
			send_txn(directed_rows[i].stim, directed_rows[i].pinned, directed_rows[i].want);

		for (int phase = 0; phase < 12; phase++) begin
			// hold off until every result is back, then let the core settle
			in_valid <= 1'b0;
			while (pending_status.size() != 0) @(negedge clk);
			repeat (20) @(negedge clk);
			load_curve(phase % 6);
			no_idle = (phase % 4 == 3);
			// long press runs drive the manual level into its upper or lower limit
			if (phase % 3 == 1) begin
				upward = $urandom_range(0, 1);
				run_len = int'($urandom_range(101, 110));
				repeat (run_len) begin
					x = random_item();
					x.press_mode = 1'b0;
					x.press_up = upward;
					x.press_down = !upward;
					send_txn(x, 1'b0, '0);
				end
			end
			repeat (80) send_txn(random_item(), 1'b0, '0);
		end

		in_valid <= 1'b0;
		no_idle = 1'b0;
		while (pending_status.size() != 0) @(negedge clk);
		repeat (40) @(posedge clk);

		$display("summary: %0d transactions sent, %0d results compared, %0d register writes",
			txn_count, result_count, write_count);
		$display("summary: reset curve plus 12 settings incl. extremes, unordered and flat breakpoints");
		if (error_count == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule
